// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; each macro expects a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/spq_pkg.sv
// Shared types and constants of the strict priority multi-class queue.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package spq_pkg;

  localparam int MAX_CLASSES_DEF = 8;
  localparam int CLASS_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int REQ_W    = 1;
  localparam int CLASS_W  = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;

  localparam logic [CFG_W-1:0] CLASSES_RESET = 4'd8;

  localparam logic [REQ_W-1:0] REQ_PUSH = 1'b0;
  localparam logic [REQ_W-1:0] REQ_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_BAD_CLASS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_HEAD_PTR,
    ST_HEAD_READ,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/strict_priority_multi_queue.sv
// Top level of the strict priority multi-class queue: sequencer and registers.
// Depends on spq_pkg, spq_class_table and spq_entry_ram.
//
//   port group | dir | transaction
//   in_*       | in  | one request: push value into class, or pop best head
//   out_*      | out | one result per request: popped, head, count, status
//   cfg_*      | in  | write of classes_in_use
//
// Each request passes through these steps in order: accept with class table read, update,
// head pointer read from the class table, head read from the entry RAM, result.
// The single read port of each memory sets that sequence.
// A finished result waits in the output register; the next request is
// accepted meanwhile and only its last step waits on out_stall.
// Synchronous reset clears control state and the class table valid bits.
`default_nettype none

module strict_priority_multi_queue #(
  parameter int MAX_CLASSES = spq_pkg::MAX_CLASSES_DEF,
  parameter int CLASS_DEPTH = spq_pkg::CLASS_DEPTH_DEF,
  parameter int DATA_WIDTH  = spq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spq_pkg::REQ_W-1:0]     in_req_type,
  input  logic [spq_pkg::CLASS_W-1:0]   in_class_index,
  input  logic [spq_pkg::VALUE_W-1:0]   in_push_value,
  input  logic                          cfg_wr_en,
  input  logic [spq_pkg::CFG_W-1:0]     cfg_wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spq_pkg::VALUE_W-1:0]   out_popped_value,
  output logic [spq_pkg::VALUE_W-1:0]   out_head_value,
  output logic                          out_head_valid,
  output logic [spq_pkg::COUNT_W-1:0]   out_total_count,
  output logic [spq_pkg::STATUS_W-1:0]  out_status
);

  import spq_pkg::*;

  localparam int CW      = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int PW      = $clog2(CLASS_DEPTH);
  localparam int CNTW    = $clog2(CLASS_DEPTH + 1);
  localparam int TW      = 2 * PW + CNTW;
  localparam int ENTRIES = MAX_CLASSES * CLASS_DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam int TOTW    = $clog2(ENTRIES + 1);

  function automatic logic [CW-1:0] first_busy(input logic [MAX_CLASSES-1:0] v);
    logic [CW-1:0] idx;
    idx = '0;
    for (int i = MAX_CLASSES - 1; i >= 0; i--) begin
      if (v[i]) idx = CW'(i);
    end
    return idx;
  endfunction

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(CLASS_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  function automatic logic [AW-1:0] entry_addr(input logic [CW-1:0] c,
                                               input logic [PW-1:0] p);
    return AW'(AW'(c) * AW'(CLASS_DEPTH) + AW'(p));
  endfunction

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]       classes_r;
  logic [REQ_W-1:0]       req_r;
  logic [DATA_WIDTH-1:0]  val_r;
  logic [CW-1:0]          tgt_r;
  logic                   bad_r;
  logic                   empty_r;
  logic [MAX_CLASSES-1:0] nonempty_r, nonempty_nxt;
  logic [TOTW-1:0]        total_r, total_nxt;
  status_t                status_r;
  logic                   pop_ok_r;
  logic [DATA_WIDTH-1:0]  popped_r;
  logic [CW-1:0]          head_cls_r;
  logic                   head_valid_r;

  logic                   out_valid_r;
  logic [VALUE_W-1:0]     out_popped_r;
  logic [VALUE_W-1:0]     out_head_r;
  logic                   out_head_valid_r;
  logic [COUNT_W-1:0]     out_total_r;
  status_t                out_status_r;

  logic          tbl_rd_en, tbl_wr_en;
  logic [CW-1:0] tbl_rd_addr;
  logic [TW-1:0] tbl_rd_data, tbl_wr_data;
  logic          mem_rd_en, mem_wr_en;
  logic [AW-1:0] mem_rd_addr, mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;
  logic          accept, out_load;

  logic [31:0]   limit;
  logic          bad_c;
  logic [CW-1:0] tgt_c;
  logic [PW-1:0] rd_ptr, wr_ptr;
  logic [CNTW-1:0] cnt;
  logic          push_ok, pop_ok;
  status_t       status_c;

  // Request decode at accept
  always_comb begin
    limit = (32'(classes_r) > 32'(MAX_CLASSES)) ? 32'(MAX_CLASSES) : 32'(classes_r);
    bad_c = (32'(in_class_index) >= limit);
    tgt_c = (in_req_type == REQ_PUSH) ? CW'(in_class_index) : first_busy(nonempty_r);
  end

  // Update step, table entry of the target class available
  always_comb begin
    rd_ptr  = tbl_rd_data[TW-1 -: PW];
    wr_ptr  = tbl_rd_data[CNTW+PW-1 -: PW];
    cnt     = tbl_rd_data[CNTW-1:0];
    push_ok = (req_r == REQ_PUSH) && !bad_r && (cnt != CNTW'(CLASS_DEPTH));
    pop_ok  = (req_r == REQ_POP) && !empty_r;
    if (req_r == REQ_POP) begin
      status_c = empty_r ? STATUS_EMPTY : STATUS_OK;
    end else if (bad_r) begin
      status_c = STATUS_BAD_CLASS;
    end else if (!push_ok) begin
      status_c = STATUS_FULL;
    end else begin
      status_c = STATUS_OK;
    end
    nonempty_nxt = nonempty_r;
    total_nxt    = total_r;
    tbl_wr_data  = tbl_rd_data;
    if (push_ok) begin
      nonempty_nxt[tgt_r] = 1'b1;
      total_nxt           = TOTW'(total_r + 1'b1);
      tbl_wr_data         = {rd_ptr, next_ptr(wr_ptr), CNTW'(cnt + 1'b1)};
    end else if (pop_ok) begin
      nonempty_nxt[tgt_r] = (cnt != CNTW'(1));
      total_nxt           = TOTW'(total_r - 1'b1);
      tbl_wr_data         = {next_ptr(rd_ptr), wr_ptr, CNTW'(cnt - 1'b1)};
    end
  end

  always_comb begin
    tbl_rd_addr = (state_r == ST_IDLE) ? tgt_c : first_busy(nonempty_r);
    mem_wr_addr = entry_addr(tgt_r, wr_ptr);
    mem_rd_addr = (state_r == ST_UPDATE) ? entry_addr(tgt_r, rd_ptr)
                                         : entry_addr(head_cls_r, rd_ptr);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_UPDATE;
      ST_UPDATE:    state_nxt = ST_HEAD_PTR;
      ST_HEAD_PTR:  state_nxt = ST_HEAD_READ;
      ST_HEAD_READ: state_nxt = ST_DONE;
      ST_DONE:      if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    tbl_rd_en = 1'b0;
    tbl_wr_en = 1'b0;
    mem_rd_en = 1'b0;
    mem_wr_en = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        accept    = in_valid;
        tbl_rd_en = in_valid;
      end
      ST_UPDATE: begin
        tbl_wr_en = push_ok || pop_ok;
        mem_wr_en = push_ok;
        mem_rd_en = pop_ok;
      end
      ST_HEAD_PTR: begin
        tbl_rd_en = 1'b1;
      end
      ST_HEAD_READ: begin
        mem_rd_en = head_valid_r;
      end
      ST_DONE: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      classes_r   <= CLASSES_RESET;
      nonempty_r  <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) classes_r <= cfg_wr_data;
      if (state_r == ST_UPDATE) begin
        nonempty_r <= nonempty_nxt;
        total_r    <= total_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      val_r   <= DATA_WIDTH'(in_push_value);
      tgt_r   <= tgt_c;
      bad_r   <= bad_c;
      empty_r <= ~|nonempty_r;
    end
    if (state_r == ST_UPDATE) begin
      status_r <= status_c;
      pop_ok_r <= pop_ok;
    end
    if (state_r == ST_HEAD_PTR) begin
      popped_r     <= pop_ok_r ? mem_rd_data : '0;
      head_cls_r   <= first_busy(nonempty_r);
      head_valid_r <= |nonempty_r;
    end
    if (out_load) begin
      out_popped_r     <= VALUE_W'(popped_r);
      out_head_r       <= head_valid_r ? VALUE_W'(mem_rd_data) : '0;
      out_head_valid_r <= head_valid_r;
      out_total_r      <= COUNT_W'(total_r);
      out_status_r     <= status_r;
    end
  end

  spq_class_table #(
    .DEPTH_N (MAX_CLASSES),
    .AW      (CW),
    .TW      (TW)
  ) u_class_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (tgt_r),
    .wr_data (tbl_wr_data)
  );

  spq_entry_ram #(
    .DEPTH_N (ENTRIES),
    .AW      (AW),
    .DW      (DATA_WIDTH)
  ) u_entry_ram (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (val_r)
  );

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_head_value   = out_head_r;
  assign out_head_valid   = out_head_valid_r;
  assign out_total_count  = out_total_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

// File: rtl/core/spq_class_table.sv
// Per-class pointer and count table: one write and one registered read port.
// Entries read as zero until first written; no package dependency.
`default_nettype none

module spq_class_table #(
  parameter int DEPTH_N = 8,
  parameter int AW      = 3,
  parameter int TW      = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [TW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [TW-1:0] wr_data
);

  logic [TW-1:0]      mem [DEPTH_N];
  logic [DEPTH_N-1:0] valid_r;
  logic [TW-1:0]      rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/spq_entry_ram.sv
// Entry storage for all classes: one write port, one registered read port.
// Contents undefined until written; no package dependency.
`default_nettype none

module spq_entry_ram #(
  parameter int DEPTH_N = 128,
  parameter int AW      = 7,
  parameter int DW      = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH_N];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/spq_checker.sv
// Port-level checker for the strict priority multi-class queue, with its bind.
// Depends on spq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [spq_pkg::VALUE_W-1:0]   out_popped_value,
  input wire logic [spq_pkg::VALUE_W-1:0]   out_head_value,
  input wire logic                          out_head_valid,
  input wire logic [spq_pkg::COUNT_W-1:0]   out_total_count,
  input wire logic [spq_pkg::STATUS_W-1:0]  out_status
);

  import spq_pkg::*;

  `ASSERT_IMPLY(a_empty_head_zero, clk, rst_n, out_valid && !out_head_valid,
                (out_head_value == '0) && (out_total_count == '0))

  `ASSERT_IMPLY(a_fail_no_pop, clk, rst_n, out_valid && (out_status != STATUS_OK),
                out_popped_value == '0)

  `ASSERT_IMPLY(a_pop_empty_stays_empty, clk, rst_n,
                out_valid && (out_status == STATUS_EMPTY),
                !out_head_valid && (out_total_count == '0))

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
               out_valid && $stable(out_head_value) && $stable(out_status))

endmodule

bind strict_priority_multi_queue spq_checker u_spq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_popped_value (out_popped_value),
  .out_head_value   (out_head_value),
  .out_head_valid   (out_head_valid),
  .out_total_count  (out_total_count),
  .out_status       (out_status)
);

`default_nettype wire
